@@ rtl/core/omp_pkg.sv @@
// ----------------------------------------------------------------------------
// omp_pkg: override mask paint composite shared types
// Word formats, mode codes, per-pixel store word and controller handshake.
// ----------------------------------------------------------------------------
package omp_pkg;

    localparam int unsigned KEPT_W = 17;
    localparam logic [7:0] FULL_MASK = 8'hFF;

    // Mode codes; codes above MODE_READ act as read only
    localparam logic [2:0] MODE_DROP  = 3'd0;
    localparam logic [2:0] MODE_KEEP  = 3'd1;
    localparam logic [2:0] MODE_CLEAR = 3'd2;
    localparam logic [2:0] MODE_LOAD  = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        stencil_bit;
        logic [7:0]  base_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        composite_value;
        logic [KEPT_W-1:0] kept_total;
        logic              pixel_changed;
        logic              out_of_range;
    } out_word_t;

    // One store entry per pixel
    typedef struct packed {
        logic [7:0] base;
        logic       drop;
        logic       keep;
    } pix_word_t;

    localparam pix_word_t PIX_RESET = '{base: FULL_MASK, drop: 1'b0, keep: 1'b0};

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic rd_issue;
        logic update;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } ctrl_sts_t;

    // Keep wins over drop, drop over base
    function automatic logic [7:0] compose(pix_word_t w);
        logic [7:0] v;
        if (w.keep)
            v = FULL_MASK;
        else if (w.drop)
            v = 8'd0;
        else
            v = w.base;
        return v;
    endfunction

endpackage

@@ rtl/core/omp_ram.sv @@
// ----------------------------------------------------------------------------
// omp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module omp_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/omp_ctrl.sv @@
// ----------------------------------------------------------------------------
// omp_ctrl: sequencing state machine
// Clearing pass after reset, then accept / read / update per word.
// ----------------------------------------------------------------------------
module omp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  omp_pkg::ctrl_sts_t sts,
    output omp_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold the pixel until the output register can take it
                if (sts.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

@@ rtl/core/omp_datapath.sv @@
// ----------------------------------------------------------------------------
// omp_datapath: pixel store, composite update and kept counter
// Holds the item, addresses the store, applies the mode, drives the output.
// ----------------------------------------------------------------------------
module omp_datapath #(
    parameter int unsigned IMG_WIDTH = 256,
    parameter int unsigned IMG_HEIGHT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  omp_pkg::ctrl_cmd_t cmd,
    output omp_pkg::ctrl_sts_t sts,
    input  omp_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output omp_pkg::out_word_t out_word
);

    localparam int unsigned DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WORD_W = $bits(omp_pkg::pix_word_t);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [omp_pkg::KEPT_W-1:0] KEPT_RESET = omp_pkg::KEPT_W'(DEPTH);
    localparam logic [12:0] WIDTH_L = 13'(IMG_WIDTH);
    localparam logic [12:0] HEIGHT_L = 13'(IMG_HEIGHT);

    omp_pkg::in_word_t          item_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic                       oor_reg;
    logic [omp_pkg::KEPT_W-1:0] kept_reg;
    logic [omp_pkg::KEPT_W-1:0] kept_next;
    logic                       out_valid_reg;
    omp_pkg::out_word_t         out_word_reg;
    omp_pkg::out_word_t         out_word_next;

    logic [24:0]          lin_addr;
    logic                 oor_now;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    omp_pkg::pix_word_t   wr_word;
    omp_pkg::pix_word_t   old_word;
    omp_pkg::pix_word_t   new_word;
    logic [WORD_W-1:0]    rd_bits;
    logic                 paint;
    logic [7:0]           was;
    logic [7:0]           now;

    // Item register
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_word;
    end

    // Pixel address and range check
    assign lin_addr = 25'(item_reg.pos_y) * 25'(IMG_WIDTH) + 25'(item_reg.pos_x);
    assign oor_now  = ({1'b0, item_reg.pos_x} >= WIDTH_L) ||
                      ({1'b0, item_reg.pos_y} >= HEIGHT_L);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            addr_reg <= lin_addr[ADDR_W-1:0];
            oor_reg  <= oor_now;
        end
    end

    // Clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear_wr)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    assign sts.clear_last = (clr_addr_reg == LAST_ADDR);

    // Mode application on the stored word
    assign old_word = omp_pkg::pix_word_t'(rd_bits);
    assign paint = item_reg.stencil_bit &&
                   ((item_reg.mode == omp_pkg::MODE_DROP) ||
                    (item_reg.mode == omp_pkg::MODE_KEEP) ||
                    (item_reg.mode == omp_pkg::MODE_CLEAR));

    always_comb
    begin
        new_word = old_word;
        case (item_reg.mode)
            omp_pkg::MODE_DROP:
            begin
                if (item_reg.stencil_bit)
                begin
                    new_word.drop = 1'b1;
                    new_word.keep = 1'b0;
                end
            end
            omp_pkg::MODE_KEEP:
            begin
                if (item_reg.stencil_bit)
                begin
                    new_word.drop = 1'b0;
                    new_word.keep = 1'b1;
                end
            end
            omp_pkg::MODE_CLEAR:
            begin
                if (item_reg.stencil_bit)
                begin
                    new_word.drop = 1'b0;
                    new_word.keep = 1'b0;
                end
            end
            omp_pkg::MODE_LOAD:
            begin
                new_word.base = item_reg.base_value;
            end
            default:
            begin
                new_word = old_word;
            end
        endcase
    end

    assign was = omp_pkg::compose(old_word);
    assign now = omp_pkg::compose(new_word);

    // Kept count follows composite transitions through zero
    always_comb
    begin
        kept_next = kept_reg;
        if (cmd.update && !oor_reg)
        begin
            if ((now != 8'd0) && (was == 8'd0))
                kept_next = kept_reg + 1'b1;
            else if ((now == 8'd0) && (was != 8'd0))
                kept_next = kept_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kept_reg <= KEPT_RESET;
        else
            kept_reg <= kept_next;
    end

    // Result word
    always_comb
    begin
        out_word_next.composite_value = oor_reg ? 8'd0 : now;
        out_word_next.kept_total      = kept_next;
        out_word_next.pixel_changed   = !oor_reg && paint &&
                                        ((new_word.drop != old_word.drop) ||
                                         (new_word.keep != old_word.keep));
        out_word_next.out_of_range    = oor_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.update)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            out_word_reg <= out_word_next;
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;

    // Store write port: clearing pass or pixel update
    assign wr_en   = cmd.clear_wr || (cmd.update && !oor_reg);
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : addr_reg;
    assign wr_word = cmd.clear_wr ? omp_pkg::PIX_RESET : new_word;

    omp_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (WORD_W'(wr_word)),
        .rd_en   (cmd.rd_issue),
        .rd_addr (lin_addr[ADDR_W-1:0]),
        .rd_data (rd_bits)
    );

endmodule

@@ rtl/core/override_mask_paint_composite.sv @@
// ----------------------------------------------------------------------------
// override_mask_paint_composite: per-pixel override mask with composite count
// Steps: accept into the item register, then store read (pixel address and
//   read data registered), then update (result registered, pixel written).
//   The read-modify-write is not overlapped: no new word is accepted until
//   the update ends; a stalled result holds the update until the output drains.
// Reset: a clearing pass fills the store with base 255 and no overrides;
//   no input word is accepted until it ends.
// ----------------------------------------------------------------------------
module override_mask_paint_composite #(
    parameter int unsigned IMG_WIDTH = 256,
    parameter int unsigned IMG_HEIGHT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  omp_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output omp_pkg::out_word_t out_word
);

    omp_pkg::ctrl_cmd_t cmd;
    omp_pkg::ctrl_sts_t sts;

    omp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    omp_datapath #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

@@ rtl/core/omp_checker.sv @@
// ----------------------------------------------------------------------------
// omp_checker: port-level checks for the override mask block
// Stall hold, out-of-range results, one word in flight, result after accept.
// ----------------------------------------------------------------------------
module omp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input omp_pkg::out_word_t out_word
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result changed while stalled");

    // Ignored pixel reports zero composite and no change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.out_of_range |->
            (out_word.composite_value == 8'd0) && !out_word.pixel_changed)
        else $error("out-of-range result carries pixel data");

    // One word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while busy");

    // Accepted word shows up on the output after the store read and update steps
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !(out_valid && out_stall) |-> ##3 out_valid)
        else $error("result missing after accept");

endmodule

bind override_mask_paint_composite omp_checker u_omp_checker (.*);
